// ===== hw/rtl/sqe_pkg.sv =====
package sqe_pkg;

  localparam int NV_W     = 3;
  localparam int SUM_W    = 52;
  localparam int TUSER_W  = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_SUM  = 2'd1,
    MODE_MEAN = 2'd2
  } mode_e;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== hw/rtl/sqe_lane.sv =====
module sqe_lane #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic                    en_i,
  input  logic [DATA_WIDTH-1:0]   label_i,
  input  logic [DATA_WIDTH-1:0]   pred_i,
  output logic [2*DATA_WIDTH-1:0] square_o
);

  logic signed [DATA_WIDTH:0]  diff;
  logic        [DATA_WIDTH:0]  mag_full;
  logic        [DATA_WIDTH-1:0] mag;
  logic [2*DATA_WIDTH-1:0]     square_d, square_q;

  always_comb begin
    diff     = $signed({label_i[DATA_WIDTH-1], label_i})
             - $signed({pred_i[DATA_WIDTH-1], pred_i});
    mag_full = diff[DATA_WIDTH] ? (~diff + 1'b1) : diff;
    mag      = mag_full[DATA_WIDTH-1:0];
    square_d = en_i ? (mag * mag) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      square_q <= square_d;
    end
  end

  assign square_o = square_q;

endmodule

// ===== hw/rtl/sqe_div.sv =====
module sqe_div #(
  parameter int DIVIDEND_W = 52,
  parameter int DIVISOR_W  = 21
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIVIDEND_W-1:0]     dividend_i,
  input  logic [DIVISOR_W-1:0]      divisor_i,
  output sqe_pkg::div_status_t      status_o,
  output logic [DIVIDEND_W-1:0]     quotient_o
);
  import sqe_pkg::*;

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  div_state_e            state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dsr_q;
  logic [DIVISOR_W:0]    trial;
  logic                  qbit;
  logic                  last_step;

  // one quotient bit per cycle, MSB first
  always_comb begin
    trial     = {rem_q, quo_q[DIVIDEND_W-1]};
    qbit      = (trial >= {1'b0, dsr_q});
    rem_d     = qbit ? DIVISOR_W'(trial - {1'b0, dsr_q}) : trial[DIVISOR_W-1:0];
    quo_d     = {quo_q[DIVIDEND_W-2:0], qbit};
    last_step = (cnt_q == LAST_STEP);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (start_i) state_d = DIV_RUN;
      DIV_RUN:  if (last_step) state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    cnt_d         = cnt_q;
    status_o.busy = 1'b0;
    status_o.done = 1'b0;
    unique case (state_q)
      DIV_IDLE: cnt_d = '0;
      DIV_RUN: begin
        status_o.busy = 1'b1;
        status_o.done = last_step;
        cnt_d         = cnt_q + 1'b1;
      end
      default: cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (state_q == DIV_RUN) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_d;

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == DIV_IDLE && start_i) |=> status_o.busy)
    else $error("divider did not start");

endmodule

// ===== hw/rtl/sqe_merge.sv =====
module sqe_merge #(
  parameter int LANES        = 4,
  parameter int SQ_W         = 32,
  parameter int CNT_W        = 21,
  parameter int MAX_ELEMENTS = 1048576
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  sqe_pkg::mode_e           mode_i,
  input  logic                     last_i,
  input  logic [LANES-1:0]         en_i,
  input  logic [LANES*SQ_W-1:0]    squares_i,
  output logic [sqe_pkg::SUM_W-1:0] sum_o,
  output logic [CNT_W-1:0]         count_o,
  output logic                     sat_o
);
  import sqe_pkg::*;

  localparam int PART_W = SQ_W + $clog2(LANES) + 1;
  localparam int ACC_W  = ((SUM_W > PART_W) ? SUM_W : PART_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

  logic [SUM_W-1:0]  sum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              sat_q;
  logic [CNT_W-1:0]  room;
  logic [LANES-1:0]  take;
  logic [PART_W-1:0] part;
  logic [ACC_W-1:0]  acc;

  // lanes past the remaining room are dropped and mark saturation
  always_comb begin
    room = CNT_MAX - cnt_q;
    part = '0;
    for (int i = 0; i < LANES; i++) begin
      take[i] = en_i[i] && (CNT_W'(i) < room);
      if (take[i]) begin
        part = part + PART_W'(squares_i[i*SQ_W +: SQ_W]);
      end
    end
    acc     = ACC_W'(sum_q) + ACC_W'(part);
    sum_o   = (acc > ACC_W'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
    count_o = cnt_q + CNT_W'($countones(take));
    sat_o   = sat_q | (|(en_i & ~take));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      sat_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        sum_q <= '0;
        cnt_q <= '0;
        sat_q <= 1'b0;
      end else if (mode_i != MODE_NONE) begin
        sum_q <= sum_o;
        cnt_q <= count_o;
        sat_q <= sat_o;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("element count above limit");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (cnt_q == CNT_MAX))
    else $error("saturation flag without full count");

endmodule

// ===== hw/rtl/squared_error_loss_core.sv =====
// channel   dir  signals                                   content
// s_axis    in   tvalid/tready/tdata/tlast                 lane labels, preds, lanes_valid
// m_axis    out  tvalid/tready/tdata/tuser/tlast           lane squares, total, flags
// cfg       in   cfg_valid/cfg_ready/cfg_data              reduction mode
//
// One item per cycle through the lane multipliers and merge adder when nothing stalls.
// A mean total waits on the radix-2 divider; input stalls once lane stage is full.
// Reset clears mode, running sum, element count and the saturation flag.
// Output register decouples sides; a stalled output holds only emitting merge steps.
module squared_error_loss_core #(
  parameter int LANES        = 4,
  parameter int DATA_WIDTH   = 16,
  parameter int MAX_ELEMENTS = 1048576,
  localparam int SQ_W  = 2 * DATA_WIDTH,
  localparam int IN_W  = ((2 * LANES * DATA_WIDTH + sqe_pkg::NV_W + 7) / 8) * 8,
  localparam int OUT_W = ((LANES * SQ_W + sqe_pkg::SUM_W + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // label_0..label_{L-1}, pred_0..pred_{L-1}, lanes_valid
  input  logic [IN_W-1:0]             s_axis_tdata_i,
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // square_0..square_{L-1}, total
  output logic [OUT_W-1:0]            m_axis_tdata_o,
  // is_total, overflow
  output logic [sqe_pkg::TUSER_W-1:0] m_axis_tuser_o,
  output logic                        m_axis_tlast_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_data_i
);
  import sqe_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  mode_e                  mode_q;
  logic                   s_fire;
  logic [NV_W-1:0]        nv;
  logic [LANES-1:0]       en_d;
  logic [LANES-1:0]       en1_q;
  logic                   v1_q;
  logic                   last1_q;
  mode_e                  mode1_q;
  logic [LANES*SQ_W-1:0]  squares;

  logic [SUM_W-1:0]       m_sum;
  logic [CNT_W-1:0]       m_count;
  logic                   m_sat;

  div_status_t            div_st;
  logic [SUM_W-1:0]       quotient;
  logic                   div_start;
  logic                   div_ovf_q;

  logic                   need_out;
  logic                   out_free;
  logic                   adv1;
  logic                   load_direct;

  logic                   out_valid_q;
  logic [LANES*SQ_W-1:0]  sq_out_q;
  logic [SUM_W-1:0]       total_q;
  logic                   is_total_q;
  logic                   ovf_q;
  logic                   last_out_q;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
    end else if (cfg_valid_i && (cfg_data_i <= MODE_MEAN)) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // lane stage
  assign nv     = s_axis_tdata_i[2*LANES*DATA_WIDTH +: NV_W];
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign en_d[i] = (int'(nv) > i);

    sqe_lane #(.DATA_WIDTH(DATA_WIDTH)) u_lane (
      .clk_i    (clk_i),
      .load_i   (s_fire),
      .en_i     (en_d[i]),
      .label_i  (s_axis_tdata_i[i*DATA_WIDTH +: DATA_WIDTH]),
      .pred_i   (s_axis_tdata_i[(LANES+i)*DATA_WIDTH +: DATA_WIDTH]),
      .square_o (squares[i*SQ_W +: SQ_W])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_fire) begin
      v1_q <= 1'b1;
    end else if (adv1) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      en1_q   <= en_d;
      last1_q <= s_axis_tlast_i;
      mode1_q <= mode_q;
    end
  end

  // merge stage
  sqe_merge #(
    .LANES        (LANES),
    .SQ_W         (SQ_W),
    .CNT_W        (CNT_W),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv1),
    .mode_i    (mode1_q),
    .last_i    (last1_q),
    .en_i      (en1_q),
    .squares_i (squares),
    .sum_o     (m_sum),
    .count_o   (m_count),
    .sat_o     (m_sat)
  );

  assign need_out    = (mode1_q == MODE_NONE) || last1_q;
  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign adv1        = v1_q && !div_st.busy && (!need_out || out_free);
  assign div_start   = adv1 && last1_q && (mode1_q == MODE_MEAN) && (m_count != '0);
  assign load_direct = adv1 && need_out && !div_start;
  assign s_axis_tready_o = !v1_q || adv1;

  sqe_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (m_sum),
    .divisor_i  (m_count),
    .status_o   (div_st),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_ovf_q <= m_sat;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_st.done || load_direct) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_st.done) begin
      sq_out_q   <= '0;
      total_q    <= quotient;
      is_total_q <= 1'b1;
      ovf_q      <= div_ovf_q;
      last_out_q <= 1'b1;
    end else if (load_direct) begin
      if (mode1_q == MODE_NONE) begin
        sq_out_q   <= squares;
        total_q    <= '0;
        is_total_q <= 1'b0;
        ovf_q      <= 1'b0;
      end else begin
        sq_out_q   <= '0;
        total_q    <= (mode1_q == MODE_MEAN) ? '0 : m_sum;
        is_total_q <= 1'b1;
        ovf_q      <= m_sat;
      end
      last_out_q <= last1_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({total_q, sq_out_q});
  assign m_axis_tuser_o  = {ovf_q, is_total_q};
  assign m_axis_tlast_o  = last_out_q;

  a_div_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> out_free)
    else $error("divider started with output occupied");

  a_no_adv_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !adv1)
    else $error("merge advanced during division");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_st.done && load_direct))
    else $error("two sources loading output register");

endmodule
